[src/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared constants, codes, state type and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_MAX_BLOCKS      = 4096;
  localparam int DEF_MAP_WORD_BITS   = 32;
  localparam int DEF_MAP_BLOCK_BYTES = 512;
  localparam int MAP_HEADER_BYTES    = 4;

  localparam int OP_W     = 2;
  localparam int NUM_W    = 12;
  localparam int TOTAL_W  = 13;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_SEEK,
    ST_FREE_CHK,
    ST_FMT_PREP,
    ST_FMT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic grant;
    logic nofree;
    logic range_err;
    logic seek_capture;
    logic free_bit;
    logic prep_step;
    logic fill_init;
    logic fill_fmt;
    logic fmt_done;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic issue_ok;
    logic chk_valid;
    logic hit;
    logic in_range;
    logic seek_hit;
    logic prep_done;
    logic last_word;
    logic out_free;
  } stat_t;

endpackage

[src/bba_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences the initial fill pass, allocate scan, free, format and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [bba_pkg::OP_W-1:0] op,
  output logic                     in_stall,
  input  bba_pkg::stat_t           stat,
  output bba_pkg::cmd_t            cmd
);
  import bba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.last_word) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(op))
            OP_ALLOC:  state_next = ST_ALLOC;
            OP_FREE:   state_next = ST_FREE_SEEK;
            OP_FORMAT: state_next = ST_FMT_PREP;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (stat.chk_valid && stat.hit) begin
          state_next = ST_DONE;
        end else if (!stat.chk_valid && !stat.issue_ok) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE_SEEK: begin
        if (!stat.in_range) begin
          state_next = ST_DONE;
        end else if (stat.seek_hit) begin
          state_next = ST_FREE_CHK;
        end
      end
      ST_FREE_CHK: state_next = ST_DONE;
      ST_FMT_PREP: begin
        if (stat.prep_done) state_next = ST_FMT_WR;
      end
      ST_FMT_WR: begin
        if (stat.last_word) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.fill_init = 1'b1;
        cmd.step      = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_ALLOC: begin
        cmd.grant  = stat.chk_valid && stat.hit;
        cmd.nofree = !stat.chk_valid && !stat.issue_ok;
        cmd.step   = stat.issue_ok && !(stat.chk_valid && stat.hit);
      end
      ST_FREE_SEEK: begin
        cmd.range_err    = !stat.in_range;
        cmd.seek_capture = stat.in_range && stat.seek_hit;
        cmd.step         = stat.in_range && !stat.seek_hit;
      end
      ST_FREE_CHK: begin
        cmd.free_bit = 1'b1;
      end
      ST_FMT_PREP: begin
        cmd.prep_step = !stat.prep_done;
      end
      ST_FMT_WR: begin
        cmd.fill_fmt = 1'b1;
        cmd.step     = 1'b1;
        cmd.fmt_done = stat.last_word;
      end
      ST_DONE: begin
        cmd.load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fill_init, cmd.fill_fmt, cmd.grant, cmd.free_bit}))
    else $error("More than one map write source is active.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> stat.out_free)
    else $error("A result was loaded over one that is still waiting.");

  a_grant_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |=> (state == ST_DONE) && !stat.chk_valid)
    else $error("The allocate scan kept running after a grant.");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("Input was open while an operation was in progress.");
`endif

endmodule

[src/bba_datapath.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Bitmap memory, scan pointers, free counter, configuration and result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MAX_BLOCKS      = bba_pkg::DEF_MAX_BLOCKS,
  parameter int MAP_WORD_BITS   = bba_pkg::DEF_MAP_WORD_BITS,
  parameter int MAP_BLOCK_BYTES = bba_pkg::DEF_MAP_BLOCK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::TOTAL_W-1:0]  cfg_data,
  input  logic [bba_pkg::NUM_W-1:0]    block_number,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bba_pkg::STATUS_W-1:0] status,
  output logic [bba_pkg::NUM_W-1:0]    allocated_block,
  output logic [bba_pkg::COUNT_W-1:0]  free_count
);
  import bba_pkg::*;

  localparam int WB     = MAP_WORD_BITS;
  localparam int DEPTH  = (MAX_BLOCKS + WB - 1) / WB;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(DEPTH * WB + WB + 1);
  localparam int OFF_W  = $clog2(WB);
  localparam int CAP    = (MAP_BLOCK_BYTES - MAP_HEADER_BYTES) * 8;
  localparam int ACC_W  = $clog2(MAX_BLOCKS + CAP + 1);

  logic [TOTAL_W-1:0] total_cfg;
  logic [IDX_W-1:0]   total;
  logic [ADDR_W-1:0]  rd_word;
  logic [IDX_W-1:0]   rd_base;
  logic               chk_valid;
  logic [ADDR_W-1:0]  chk_word;
  logic [IDX_W-1:0]   chk_base;
  logic [NUM_W-1:0]   num_q;
  logic [OFF_W-1:0]   off_q;
  logic [ACC_W-1:0]   acc;
  logic [IDX_W-1:0]   reserve;
  logic [COUNT_W-1:0] free_blocks;
  status_t            res_status;
  logic [NUM_W-1:0]   res_block;

  logic [WB-1:0]      rdata;
  logic [WB-1:0]      free_bits;
  logic [WB-1:0]      fmt_word;
  logic [WB-1:0]      wdata;
  logic [ADDR_W-1:0]  waddr;
  logic               we;
  logic [OFF_W-1:0]   pos;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(total_cfg) > 32'(MAX_BLOCKS)) begin
      total = IDX_W'(MAX_BLOCKS);
    end else begin
      total = IDX_W'(total_cfg);
    end
  end

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      free_bits[j] = !rdata[j] && ((32'(chk_base) + 32'(j)) < 32'(total));
      fmt_word[j]  = ((32'(rd_base) + 32'(j)) < 32'(reserve)) ||
                     ((32'(rd_base) + 32'(j)) >= 32'(total));
    end
  end

  always_comb begin
    pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (free_bits[j]) pos = OFF_W'(j);
    end
  end

  always_comb begin
    stat.issue_ok  = rd_base < total;
    stat.chk_valid = chk_valid;
    stat.hit       = |free_bits;
    stat.in_range  = 32'(num_q) < 32'(total);
    stat.seek_hit  = 32'(num_q) < (32'(rd_base) + 32'(WB));
    stat.prep_done = 32'(acc) >= 32'(total);
    stat.last_word = rd_word == ADDR_W'(DEPTH - 1);
    stat.out_free  = !out_valid || !out_stall;
  end

  always_comb begin
    we    = cmd.fill_init || cmd.fill_fmt || cmd.grant || cmd.free_bit;
    waddr = (cmd.fill_init || cmd.fill_fmt) ? rd_word : chk_word;
    if (cmd.fill_init) begin
      wdata = '1;
    end else if (cmd.fill_fmt) begin
      wdata = fmt_word;
    end else if (cmd.grant) begin
      wdata = rdata | (WB'(1) << pos);
    end else begin
      wdata = rdata & ~(WB'(1) << off_q);
    end
  end

  bba_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_word),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_cfg   <= TOTAL_RESET;
      rd_word     <= '0;
      rd_base     <= '0;
      chk_valid   <= 1'b0;
      free_blocks <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        total_cfg <= cfg_data;
      end
      chk_valid <= cmd.step;
      if (cmd.accept) begin
        rd_word <= '0;
        rd_base <= '0;
      end else if (cmd.step) begin
        rd_word <= rd_word + ADDR_W'(1);
        rd_base <= rd_base + IDX_W'(WB);
      end
      if (cmd.grant) begin
        free_blocks <= free_blocks - COUNT_W'(1);
      end else if (cmd.free_bit && rdata[off_q]) begin
        free_blocks <= free_blocks + COUNT_W'(1);
      end else if (cmd.fmt_done) begin
        if (total > reserve) begin
          free_blocks <= COUNT_W'(total - reserve);
        end else begin
          free_blocks <= '0;
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_word <= rd_word;
    chk_base <= rd_base;
    if (cmd.accept) begin
      num_q      <= block_number;
      acc        <= '0;
      reserve    <= IDX_W'(1);
      res_status <= STS_OK;
      res_block  <= '0;
    end
    if (cmd.prep_step) begin
      acc     <= acc + ACC_W'(CAP);
      reserve <= reserve + IDX_W'(1);
    end
    if (cmd.seek_capture) begin
      off_q <= OFF_W'(32'(num_q) - 32'(rd_base));
    end
    if (cmd.grant) begin
      res_block <= NUM_W'(32'(chk_base) + 32'(pos));
    end
    if (cmd.nofree) begin
      res_status <= STS_NO_FREE;
    end
    if (cmd.range_err) begin
      res_status <= STS_RANGE;
    end
    if (cmd.load) begin
      status          <= res_status;
      allocated_block <= res_block;
      free_count      <= free_blocks;
    end
  end

endmodule

[src/block_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator unit
// First-fit allocator over a used/free bitmap of storage blocks.
// ----------------------------------------------------------------------------
// Usage: an operation (op, block_number) transfers on the input channel when
// in_valid is high and in_stall is low. Each operation returns exactly one
// result (status, allocated_block, free_count) on the output channel, which
// transfers when out_valid is high and out_stall is low. The block count
// register is written through cfg_valid/cfg_ready/cfg_data; the user must do
// so only while idle, as the block itself does not enforce it.
// One operation is in progress at a time. Allocate reads one bitmap word per
// cycle from the map memory until it finds a free block in a word or has
// passed the map words below the block count. Free walks to the word that
// holds the block. Format sizes the reserved area and then
// writes every map word (128 at the defaults).
// The result sits in an output register, so the next operation is accepted
// while a result waits; a stalled receiver only holds the next result back.
// After reset the map memory is filled with ones, one word per cycle (128
// words at the defaults), and in_stall stays high until that pass is done.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit #(
  parameter int MAX_BLOCKS      = bba_pkg::DEF_MAX_BLOCKS,
  parameter int MAP_WORD_BITS   = bba_pkg::DEF_MAP_WORD_BITS,
  parameter int MAP_BLOCK_BYTES = bba_pkg::DEF_MAP_BLOCK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::TOTAL_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bba_pkg::OP_W-1:0]     op,
  input  logic [bba_pkg::NUM_W-1:0]    block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bba_pkg::STATUS_W-1:0] status,
  output logic [bba_pkg::NUM_W-1:0]    allocated_block,
  output logic [bba_pkg::COUNT_W-1:0]  free_count
);
  import bba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAP_WORD_BITS   (MAP_WORD_BITS),
    .MAP_BLOCK_BYTES (MAP_BLOCK_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .block_number    (block_number),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .allocated_block (allocated_block),
    .free_count      (free_count)
  );

endmodule

[sim/block_bitmap_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator unit testbench
// Drives allocate, free, format and unused operations through the input
// channel, rewrites the block count between phases, and checks every result
// against a bit-exact model of the bitmap and the free counter kept in a
// scoreboard. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int MAXB          = DEF_MAX_BLOCKS;
  localparam int CAPACITY      = (DEF_MAP_BLOCK_BYTES - MAP_HEADER_BYTES) * 8;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    blk;
    logic [COUNT_W-1:0]  cnt;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [MAXB-1:0]      taken;
    logic [COUNT_W-1:0] avail;
    logic [TOTAL_W-1:0] blocks_cfg;
    alloc_result_t      pending_q[$];
    int unsigned        fails;

    function new();
      taken      = '1;
      avail      = '0;
      blocks_cfg = TOTAL_RESET;
      fails      = 0;
    endfunction

    function int unsigned limit();
      return (blocks_cfg > MAXB) ? MAXB : blocks_cfg;
    endfunction

    function void note_request(op_t code, logic [NUM_W-1:0] num);
      int unsigned   lim;
      int unsigned   reserve;
      int unsigned   cnt;
      alloc_result_t r;
      lim      = limit();
      r.status = STS_OK;
      r.blk    = '0;
      case (code)
        OP_ALLOC: begin
          r.status = STS_NO_FREE;
          for (int i = 0; i < lim; i++) begin
            if (!taken[i]) begin
              taken[i] = 1'b1;
              avail    = avail - 1'b1;
              r.blk    = NUM_W'(i);
              r.status = STS_OK;
              break;
            end
          end
        end
        OP_FREE: begin
          if (num >= lim) begin
            r.status = STS_RANGE;
          end else if (taken[num]) begin
            taken[num] = 1'b0;
            avail      = avail + 1'b1;
          end
        end
        OP_FORMAT: begin
          // The header block and the map blocks at the bottom stay reserved.
          reserve = (lim + CAPACITY - 1) / CAPACITY + 1;
          cnt     = 0;
          for (int i = 0; i < MAXB; i++) begin
            taken[i] = (i < reserve) || (i >= lim);
            if (!taken[i]) cnt++;
          end
          avail = COUNT_W'(cnt);
        end
        default: ;
      endcase
      r.cnt = avail;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [NUM_W-1:0] blk,
                               logic [COUNT_W-1:0] cnt);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("Unexpected result: status %0d block %0d free %0d", st, blk, cnt);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status || blk !== e.blk || cnt !== e.cnt) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("Mismatch: status %0d/%0d block %0d/%0d free %0d/%0d (expected/actual)",
                   e.status, st, e.blk, blk, e.cnt, cnt);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TOTAL_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = '0;
  logic [NUM_W-1:0]    block_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [NUM_W-1:0]    allocated_block;
  logic [COUNT_W-1:0]  free_count;
  bit                  steady = 1'b0;
  int unsigned         cycles = 0;
  alloc_scoreboard     sb = new();

  block_bitmap_allocator_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .block_number    (block_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .allocated_block (allocated_block),
    .free_count      (free_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", sb.pending_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_request(op_t code, logic [NUM_W-1:0] num);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op           = code;
    block_number = num;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(code, num);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_total(logic [TOTAL_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.blocks_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(status, allocated_block, free_count);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned        lim;
    int unsigned        pick;
    int unsigned        span;
    int unsigned        sent;
    logic [NUM_W-1:0]   num;
    logic [TOTAL_W-1:0] tot;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset every block is marked used, so high grants are easy to reach.
    send_request(OP_ALLOC, '0);
    send_request(OP_NOP, '1);
    send_request(OP_FREE, 12'd4095);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd2048);
    send_request(OP_FREE, 12'd2048);
    send_request(OP_ALLOC, '1);
    send_request(OP_FORMAT, '0);
    send_request(OP_FREE, 12'd0);
    send_request(OP_FREE, 12'd1);
    send_request(OP_ALLOC, '0);
    write_total(13'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd0);
    send_request(OP_FORMAT, '0);
    write_total(13'd8191);
    send_request(OP_FORMAT, '0);
    write_total(13'd1);
    send_request(OP_FORMAT, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd1);
    write_total(13'd4065);
    send_request(OP_FORMAT, '0);
    write_total(13'd3);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd2);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) tot = '0;
      else if (pick == 1) tot = TOTAL_W'($urandom_range(4097, 8191));
      else if (pick == 2) tot = TOTAL_RESET;
      else if (pick < 9) tot = TOTAL_W'($urandom_range(1, 48));
      else if (pick < 14) tot = TOTAL_W'($urandom_range(49, 700));
      else tot = TOTAL_W'($urandom_range(701, 4095));
      write_total(tot);
      steady = ($urandom_range(0, 3) == 0);
      // Most phases start from a fresh map; the rest keep the old one.
      if ($urandom_range(0, 7) != 0) send_request(OP_FORMAT, NUM_W'($urandom));
      lim  = sb.limit();
      span = $urandom_range(20, 60);
      repeat (span) begin
        pick = $urandom_range(0, 99);
        num  = NUM_W'($urandom);
        if (pick < 45) begin
          send_request(OP_ALLOC, num);
        end else if (pick < 80) begin
          if (lim > 0) num = NUM_W'($urandom_range(0, lim - 1));
          send_request(OP_FREE, num);
        end else if (pick < 88) begin
          send_request(OP_FREE, num);
        end else if (pick < 93) begin
          send_request(OP_FORMAT, num);
        end else if (pick < 97) begin
          send_request(OP_NOP, num);
        end else begin
          drain();
          send_request(OP_ALLOC, num);
        end
        sent++;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_datapath.sv
src/block_bitmap_allocator_unit.sv
sim/block_bitmap_allocator_unit_tb.sv
